### rtl/scp_pkg.sv
// Shared types and constants for the second-chance page replacement block.
`timescale 1ns / 1ps
package scp_pkg;

  localparam int SCP_MAX_ENTRIES = 16;
  localparam int SCP_PAGE_W      = 16;
  localparam int SCP_IDX_W       = $clog2(SCP_MAX_ENTRIES);
  localparam int SCP_CNT_W       = SCP_IDX_W + 1;
  localparam int SCP_CFG_W       = 5;
  localparam int SCP_CMP_W       = (SCP_CFG_W > SCP_CNT_W) ? SCP_CFG_W : SCP_CNT_W;
  localparam logic [SCP_CFG_W-1:0] SCP_CFG_RESET = SCP_CFG_W'(16);

  localparam int SCP_SLOT_W  = 4;
  localparam int SCP_TOTAL_W = 32;
  localparam logic [SCP_TOTAL_W-1:0] SCP_TOTAL_MAX = '1;

  localparam int SCP_IN_DATA_W  = ((SCP_PAGE_W + 7) / 8) * 8;
  localparam int SCP_OUT_BITS   = 1 + SCP_SLOT_W + 1 + SCP_PAGE_W + 2 * SCP_TOTAL_W;
  localparam int SCP_OUT_DATA_W = ((SCP_OUT_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    SCP_IDLE,
    SCP_LOOKUP,
    SCP_SCAN
  } scp_state_t;

  // per-cell command from the controller
  typedef struct packed {
    logic wr;       // load the requested page, valid, reference clear
    logic set_ref;  // hit: mark referenced
    logic clr_ref;  // scan: give a second chance
  } scp_cell_ctl_t;

  // values carried from cell to cell along the row
  typedef struct packed {
    logic                  hit_seen;
    logic                  free_seen;
    logic                  sel_ref;
    logic [SCP_PAGE_W-1:0] sel_tag;
  } scp_chain_t;

endpackage

### rtl/scp_cell.sv
// One table entry: tag, valid and reference bit, with its link in the priority chain.
`timescale 1ns / 1ps
module scp_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [scp_pkg::SCP_PAGE_W-1:0] page,
  input  logic                          active,
  input  logic                          sel,
  input  scp_pkg::scp_cell_ctl_t        ctl,
  input  scp_pkg::scp_chain_t           chain_in,
  output scp_pkg::scp_chain_t           chain_out,
  output logic                          hit_first,
  output logic                          free_first
);

  logic [scp_pkg::SCP_PAGE_W-1:0] tag_r;
  logic                           valid_r;
  logic                           ref_r;
  logic                           match;
  logic                           free;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      tag_r <= page;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ref_r   <= 1'b0;
    end else if (ctl.wr) begin
      valid_r <= 1'b1;
      ref_r   <= 1'b0;
    end else if (ctl.set_ref) begin
      ref_r <= 1'b1;
    end else if (ctl.clr_ref) begin
      ref_r <= 1'b0;
    end
  end

  assign match = active && valid_r && (tag_r == page);
  assign free  = active && !valid_r;

  // lowest cell wins: pass what was seen below on to the next cell
  assign hit_first  = match && !chain_in.hit_seen;
  assign free_first = free && !chain_in.free_seen;

  always_comb begin
    chain_out.hit_seen  = chain_in.hit_seen | match;
    chain_out.free_seen = chain_in.free_seen | free;
    chain_out.sel_ref   = chain_in.sel_ref | (sel & ref_r);
    chain_out.sel_tag   = chain_in.sel_tag | (sel ? tag_r : '0);
  end

endmodule

### rtl/second_chance_page_replacement_top.sv
// Top level: request control, clock hand and the row of table cells.
`timescale 1ns / 1ps
// Second-chance (clock) page replacement over a row of table cells. A request is
// taken into the page register, then matched in parallel along the cell row. A
// fault on a full table then steps the clock hand one entry per cycle, clearing
// set reference bits, until it finds a clear one. The result stays in an output
// register while the next request is accepted. The table size is cfg_wdata
// clamped to 1..16, written through cfg_we. The user must write it only while
// no request is pending; the block itself does not enforce this.
module second_chance_page_replacement_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [15:0] page_number
  input  logic [scp_pkg::SCP_IN_DATA_W-1:0]   in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] hit, [4:1] slot, [5] evicted_valid, [21:6] evicted_page,
  // [53:22] fault_count, [85:54] request_count, [87:86] zero
  output logic [scp_pkg::SCP_OUT_DATA_W-1:0]  out_tdata,
  input  logic                                cfg_we,
  input  logic [scp_pkg::SCP_CFG_W-1:0]       cfg_wdata
);

  localparam int N  = scp_pkg::SCP_MAX_ENTRIES;
  localparam int IW = scp_pkg::SCP_IDX_W;
  localparam int CW = scp_pkg::SCP_CNT_W;
  localparam int PW = scp_pkg::SCP_PAGE_W;
  localparam int TW = scp_pkg::SCP_TOTAL_W;

  scp_pkg::scp_state_t state_r, state_nxt;
  logic [PW-1:0] page_r, page_nxt;
  logic [IW-1:0] hand_r, hand_nxt;
  logic [IW-1:0] scan_r, scan_nxt;
  logic [TW-1:0] faults_r, faults_nxt;
  logic [TW-1:0] reqs_r, reqs_nxt;
  logic [scp_pkg::SCP_CFG_W-1:0] cfg_r;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_hit_r, out_hit_nxt;
  logic [scp_pkg::SCP_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic                          out_ev_r, out_ev_nxt;
  logic [PW-1:0]                 out_evp_r, out_evp_nxt;
  logic [TW-1:0]                 out_faults_r, out_faults_nxt;
  logic [TW-1:0]                 out_reqs_r, out_reqs_nxt;

  logic [scp_pkg::SCP_CMP_W-1:0] cfg_ext;
  logic [CW-1:0]                 n_w;
  logic [N-1:0]                  active;
  logic [N-1:0]                  sel;
  logic [N-1:0]                  hit_hot;
  logic [N-1:0]                  free_hot;
  logic [IW-1:0]                 hit_idx;
  logic [IW-1:0]                 free_idx;
  logic [IW-1:0]                 start_hand;
  logic [IW-1:0]                 cur_hand;
  logic [IW-1:0]                 next_hand;
  logic [CW-1:0]                 cur_plus;
  logic                          can_emit;

  scp_pkg::scp_cell_ctl_t ctl [N];
  scp_pkg::scp_chain_t    chain [N+1];

  // table size in use, clamped to 1..N
  always_comb begin
    cfg_ext = scp_pkg::SCP_CMP_W'(cfg_r);
    if (cfg_r == '0) begin
      n_w = CW'(1);
    end else if (cfg_ext > scp_pkg::SCP_CMP_W'(N)) begin
      n_w = CW'(N);
    end else begin
      n_w = CW'(cfg_ext);
    end
  end

  assign start_hand = (CW'(hand_r) >= n_w) ? '0 : hand_r;
  assign cur_hand   = (state_r == scp_pkg::SCP_SCAN) ? scan_r : start_hand;
  assign cur_plus   = CW'(cur_hand) + CW'(1);
  assign next_hand  = (cur_plus >= n_w) ? '0 : IW'(cur_plus);

  assign chain[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign active[i] = (CW'(i) < n_w);
    assign sel[i]    = (cur_hand == IW'(i));
    scp_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .page       (page_r),
      .active     (active[i]),
      .sel        (sel[i]),
      .ctl        (ctl[i]),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1]),
      .hit_first  (hit_hot[i]),
      .free_first (free_hot[i])
    );
  end

  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (hit_hot[i]) hit_idx = hit_idx | IW'(i);
      if (free_hot[i]) free_idx = free_idx | IW'(i);
    end
  end

  assign can_emit = !out_valid_r || out_tready;

  always_comb begin
    state_nxt      = state_r;
    page_nxt       = page_r;
    hand_nxt       = hand_r;
    scan_nxt       = scan_r;
    faults_nxt     = faults_r;
    reqs_nxt       = reqs_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_hit_nxt    = out_hit_r;
    out_slot_nxt   = out_slot_r;
    out_ev_nxt     = out_ev_r;
    out_evp_nxt    = out_evp_r;
    out_faults_nxt = out_faults_r;
    out_reqs_nxt   = out_reqs_r;
    in_tready      = 1'b0;
    for (int i = 0; i < N; i++) begin
      ctl[i] = '0;
    end

    case (state_r)
      scp_pkg::SCP_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          page_nxt  = in_tdata[PW-1:0];
          state_nxt = scp_pkg::SCP_LOOKUP;
        end
      end
      scp_pkg::SCP_LOOKUP: begin
        if (chain[N].hit_seen || chain[N].free_seen) begin
          if (can_emit) begin
            reqs_nxt = (reqs_r == scp_pkg::SCP_TOTAL_MAX) ? reqs_r : reqs_r + TW'(1);
            out_valid_nxt = 1'b1;
            out_ev_nxt    = 1'b0;
            out_evp_nxt   = '0;
            out_reqs_nxt  = reqs_nxt;
            if (chain[N].hit_seen) begin
              for (int i = 0; i < N; i++) begin
                ctl[i].set_ref = hit_hot[i];
              end
              out_hit_nxt  = 1'b1;
              out_slot_nxt = scp_pkg::SCP_SLOT_W'(hit_idx);
            end else begin
              for (int i = 0; i < N; i++) begin
                ctl[i].wr = free_hot[i];
              end
              faults_nxt = (faults_r == scp_pkg::SCP_TOTAL_MAX) ?
                           faults_r : faults_r + TW'(1);
              out_hit_nxt  = 1'b0;
              out_slot_nxt = scp_pkg::SCP_SLOT_W'(free_idx);
            end
            out_faults_nxt = faults_nxt;
            state_nxt      = scp_pkg::SCP_IDLE;
          end
        end else begin
          scan_nxt  = start_hand;
          state_nxt = scp_pkg::SCP_SCAN;
        end
      end
      scp_pkg::SCP_SCAN: begin
        if (chain[N].sel_ref) begin
          // second chance: clear and move on
          for (int i = 0; i < N; i++) begin
            ctl[i].clr_ref = sel[i];
          end
          scan_nxt = next_hand;
        end else if (can_emit) begin
          for (int i = 0; i < N; i++) begin
            ctl[i].wr = sel[i];
          end
          hand_nxt   = next_hand;
          faults_nxt = (faults_r == scp_pkg::SCP_TOTAL_MAX) ? faults_r : faults_r + TW'(1);
          reqs_nxt   = (reqs_r == scp_pkg::SCP_TOTAL_MAX) ? reqs_r : reqs_r + TW'(1);
          out_valid_nxt  = 1'b1;
          out_hit_nxt    = 1'b0;
          out_slot_nxt   = scp_pkg::SCP_SLOT_W'(scan_r);
          out_ev_nxt     = 1'b1;
          out_evp_nxt    = chain[N].sel_tag;
          out_faults_nxt = faults_nxt;
          out_reqs_nxt   = reqs_nxt;
          state_nxt      = scp_pkg::SCP_IDLE;
        end
      end
      default: begin
        state_nxt = scp_pkg::SCP_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= scp_pkg::SCP_IDLE;
      hand_r      <= '0;
      scan_r      <= '0;
      faults_r    <= '0;
      reqs_r      <= '0;
      cfg_r       <= scp_pkg::SCP_CFG_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hand_r      <= hand_nxt;
      scan_r      <= scan_nxt;
      faults_r    <= faults_nxt;
      reqs_r      <= reqs_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r       <= page_nxt;
    out_hit_r    <= out_hit_nxt;
    out_slot_r   <= out_slot_nxt;
    out_ev_r     <= out_ev_nxt;
    out_evp_r    <= out_evp_nxt;
    out_faults_r <= out_faults_nxt;
    out_reqs_r   <= out_reqs_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = scp_pkg::SCP_OUT_DATA_W'({out_reqs_r, out_faults_r, out_evp_r,
                                                out_ev_r, out_slot_r, out_hit_r});

endmodule

### rtl/scp_checker.sv
// Port-level checks for the second-chance page replacement top, bound to it.
`timescale 1ns / 1ps
module scp_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [scp_pkg::SCP_OUT_DATA_W-1:0] out_tdata
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one request at a time: after accepting, the lookup cycle follows
  a_one_pending: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted during lookup");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[5])
    else $error("hit reported an eviction");

  // faults never outnumber requests
  a_fault_le_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[53:22] <= out_tdata[85:54])
    else $error("fault count above request count");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind second_chance_page_replacement_top scp_checker u_scp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/second_chance_page_replacement_top_tb.sv
// Testbench for the second-chance page replacement block: predicted results vs. the stream.
`timescale 1ns / 1ps
module second_chance_page_replacement_top_tb;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT    = 37;
  localparam int PHASE_ITEMS = 48;
  localparam int NUM_PHASES  = 10;

  typedef struct packed {
    logic                            hit;
    logic [scp_pkg::SCP_SLOT_W-1:0]  slot;
    logic                            evicted_valid;
    logic [scp_pkg::SCP_PAGE_W-1:0]  evicted_page;
    logic [scp_pkg::SCP_TOTAL_W-1:0] fault_count;
    logic [scp_pkg::SCP_TOTAL_W-1:0] request_count;
  } page_result_t;

  // Tracks the page table and the saturating counters, queues predicted results
  // per accepted request and checks each returned item against the oldest one.
  class page_table_tracker;
    logic [scp_pkg::SCP_PAGE_W-1:0]  tags [scp_pkg::SCP_MAX_ENTRIES];
    bit                              valid [scp_pkg::SCP_MAX_ENTRIES];
    bit                              refd [scp_pkg::SCP_MAX_ENTRIES];
    int                              hand;
    logic [scp_pkg::SCP_TOTAL_W-1:0] faults;
    logic [scp_pkg::SCP_TOTAL_W-1:0] requests;
    logic [scp_pkg::SCP_CFG_W-1:0]   size_reg;
    page_result_t                    expected_results [$];
    int                              mismatches;

    function new();
      for (int i = 0; i < scp_pkg::SCP_MAX_ENTRIES; i++) begin
        tags[i]  = '0;
        valid[i] = 1'b0;
        refd[i]  = 1'b0;
      end
      hand       = 0;
      faults     = '0;
      requests   = '0;
      size_reg   = scp_pkg::SCP_CFG_RESET;
      mismatches = 0;
    endfunction

    function void set_table_size(logic [scp_pkg::SCP_CFG_W-1:0] v);
      size_reg = v;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    // Work out the lookup, fill or clock-hand eviction for one page.
    function void note_request(logic [scp_pkg::SCP_PAGE_W-1:0] page);
      page_result_t res;
      int           n;
      int           h;
      bit           found;
      res = '0;
      n = int'(size_reg);
      if (n < 1) n = 1;
      if (n > scp_pkg::SCP_MAX_ENTRIES) n = scp_pkg::SCP_MAX_ENTRIES;
      found = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!found && valid[i] && tags[i] == page) begin
          found    = 1'b1;
          res.hit  = 1'b1;
          res.slot = i[scp_pkg::SCP_SLOT_W-1:0];
        end
      end
      if (res.hit) begin
        refd[res.slot] = 1'b1;
      end else begin
        found = 1'b0;
        for (int i = 0; i < n; i++) begin
          if (!found && !valid[i]) begin
            found    = 1'b1;
            res.slot = i[scp_pkg::SCP_SLOT_W-1:0];
          end
        end
        if (!found) begin
          // restart the hand when the table shrank under it
          h = (hand >= n) ? 0 : hand;
          while (refd[h]) begin
            refd[h] = 1'b0;
            h = (h + 1 >= n) ? 0 : h + 1;
          end
          res.slot          = h[scp_pkg::SCP_SLOT_W-1:0];
          res.evicted_valid = 1'b1;
          res.evicted_page  = tags[h];
          hand = (h + 1 >= n) ? 0 : h + 1;
        end
        tags[res.slot]  = page;
        valid[res.slot] = 1'b1;
        refd[res.slot]  = 1'b0;
        if (faults != scp_pkg::SCP_TOTAL_MAX) faults = faults + 1'b1;
      end
      if (requests != scp_pkg::SCP_TOTAL_MAX) requests = requests + 1'b1;
      res.fault_count   = faults;
      res.request_count = requests;
      expected_results.push_back(res);
    endfunction

    task check_result(logic [scp_pkg::SCP_OUT_DATA_W-1:0] data);
      page_result_t got;
      page_result_t exp;
      got.hit           = data[0];
      got.slot          = data[4:1];
      got.evicted_valid = data[5];
      got.evicted_page  = data[21:6];
      got.fault_count   = data[53:22];
      got.request_count = data[85:54];
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing expected, data 0x%h", data));
      end else begin
        exp = expected_results.pop_front();
        if (got.hit != exp.hit)
          report($sformatf("hit got %0d exp %0d", got.hit, exp.hit));
        if (got.slot != exp.slot)
          report($sformatf("slot got %0d exp %0d", got.slot, exp.slot));
        if (got.evicted_valid != exp.evicted_valid)
          report($sformatf("evicted_valid got %0d exp %0d",
                           got.evicted_valid, exp.evicted_valid));
        if (got.evicted_page != exp.evicted_page)
          report($sformatf("evicted_page got 0x%h exp 0x%h",
                           got.evicted_page, exp.evicted_page));
        if (got.fault_count != exp.fault_count)
          report($sformatf("fault_count got %0d exp %0d",
                           got.fault_count, exp.fault_count));
        if (got.request_count != exp.request_count)
          report($sformatf("request_count got %0d exp %0d",
                           got.request_count, exp.request_count));
      end
    endtask
  endclass

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [scp_pkg::SCP_IN_DATA_W-1:0]   in_tdata = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [scp_pkg::SCP_OUT_DATA_W-1:0]  out_tdata;
  logic                                cfg_we = 1'b0;
  logic [scp_pkg::SCP_CFG_W-1:0]       cfg_wdata = '0;

  page_table_tracker              tracker = new();
  bit                             idle_en = 1'b1;
  bit                             hold_req = 1'b0;
  logic [scp_pkg::SCP_PAGE_W-1:0] page_pool [$];

  second_chance_page_replacement_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // Offer one page, with random idle cycles ahead of it; valid stays high on return.
  task send_page(input logic [scp_pkg::SCP_PAGE_W-1:0] page);
    while (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= scp_pkg::SCP_IN_DATA_W'(page);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.note_request(page);
  endtask

  task wait_drain();
    in_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task write_table_size(input logic [scp_pkg::SCP_CFG_W-1:0] v);
    wait_drain();
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.set_table_size(v);
  endtask

  // Draw mostly from a pool a little larger than the table, with some noise.
  function logic [scp_pkg::SCP_PAGE_W-1:0] pick_page();
    if ($urandom_range(99) < 10 || page_pool.size() == 0)
      return scp_pkg::SCP_PAGE_W'($urandom_range(0, 65535));
    return page_pool[$urandom_range(0, page_pool.size() - 1)];
  endfunction

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int  hold_left;
    bit  ready_next;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      if (hold_left > 0) begin
        ready_next = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_CYCLES;
        ready_next = 1'b0;
      end else begin
        ready_next = !(idle_en && $urandom_range(99) < IDLE_PCT);
      end
      out_tready <= ready_next;
      @(posedge clk);
      if (out_tvalid && out_tready) tracker.check_result(out_tdata);
    end
  end

  initial begin
    logic [scp_pkg::SCP_CFG_W-1:0] size_sel;
    int                            pool_len;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size of 16: page extremes, a repeat hit, free-entry fills
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h8001);
    send_page(16'h5555);
    send_page(16'hAAAA);
    // two entries: hits, then clock-hand evictions; leaves a duplicate of 8001 above
    write_table_size(5'd2);
    send_page(16'h0000);
    send_page(16'hFFFF);
    send_page(16'h8001);
    send_page(16'h1234);
    send_page(16'h8001);
    // zero acts as one
    write_table_size(5'd0);
    send_page(16'h1234);
    send_page(16'h4321);
    send_page(16'h4321);
    // oversize clamps to 16: hits above the old size and free-entry fills
    write_table_size(5'd31);
    send_page(16'h8001);
    send_page(16'h0000);
    send_page(16'hAAAA);
    send_page(16'hFFFF);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: size_sel = 5'd16;
        1: size_sel = 5'd1;
        2: size_sel = 5'd31;
        3: size_sel = 5'd0;
        default: size_sel = 5'($urandom_range(0, 31));
      endcase
      write_table_size(size_sel);
      idle_en = (ph != 4);
      if (ph == 5) hold_req = 1'b1;
      pool_len = ((size_sel == 0) ? 1 : (size_sel > 16) ? 16 : int'(size_sel))
                 + $urandom_range(1, 4);
      page_pool.delete();
      for (int k = 0; k < pool_len; k++)
        page_pool.push_back(scp_pkg::SCP_PAGE_W'($urandom_range(0, 65535)));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // pause the sender until the block has returned everything
        if (ph == 6 && k == PHASE_ITEMS / 2) wait_drain();
        send_page(pick_page());
      end
    end
    idle_en = 1'b1;

    wait_drain();
    repeat (40) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d results never arrived", tracker.pending()));
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/scp_pkg.sv
rtl/scp_cell.sv
rtl/second_chance_page_replacement_top.sv
rtl/scp_checker.sv
tb/second_chance_page_replacement_top_tb.sv
